/* src/pst_pkg.sv */
// Shared types and constants for the packed slot table.
// Holds the table sizes, the transfer payload structs and the memory request structs.
// No dependencies.
`default_nettype none

package pst_pkg;

	// Table geometry.
	localparam int CAPACITY   = 256;
	localparam int ID_BITS    = 10;
	localparam int SLOT_BITS  = $clog2(CAPACITY);
	localparam int COUNT_BITS = $clog2(CAPACITY + 1);
	localparam int MAP_DEPTH  = 1 << ID_BITS;

	// Fixed payload field widths.
	localparam int ACTION_W = 2;
	localparam int HANDLE_W = 10;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 8;
	localparam int COUNT_W  = 9;

	typedef logic [ACTION_W-1:0] action_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam action_t ACT_CREATE  = 2'd0;
	localparam action_t ACT_DESTROY = 2'd1;
	localparam action_t ACT_LOOKUP  = 2'd2;

	localparam status_t STS_OK   = 2'd0;
	localparam status_t STS_DEAD = 2'd1;
	localparam status_t STS_FULL = 2'd2;
	localparam status_t STS_WRAP = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_FIX,
		S_DONE
	} fsm_state_t;

	typedef struct packed {
		action_t             action;
		logic [HANDLE_W-1:0] handle;
	} req_t;

	typedef struct packed {
		status_t             status;
		logic [HANDLE_W-1:0] new_handle;
		logic [SLOT_W-1:0]   slot;
		logic                moved;
		logic [SLOT_W-1:0]   moved_from;
		logic [COUNT_W-1:0]  live_count;
	} rsp_t;

	typedef struct packed {
		logic                 valid;
		logic [SLOT_BITS-1:0] slot;
	} map_entry_t;

	typedef struct packed {
		logic               rd_en;
		logic [ID_BITS-1:0] rd_addr;
		logic               wr_en;
		logic [ID_BITS-1:0] wr_addr;
		map_entry_t         wr_data;
	} map_req_t;

	typedef struct packed {
		logic                 rd_en;
		logic [SLOT_BITS-1:0] rd_addr;
		logic                 wr_en;
		logic [SLOT_BITS-1:0] wr_addr;
		logic [ID_BITS-1:0]   wr_data;
	} own_req_t;

endpackage

`default_nettype wire

/* src/pst_map_store.sv */
// Handle map memory: one entry per handle id with a valid flag and a slot.
// Runs a clearing sweep over every entry after reset.
// Depends on pst_pkg.
`default_nettype none

module pst_map_store (
	input  wire                     clk,
	input  wire                     arst_n,
	input  pst_pkg::map_req_t       req,
	output pst_pkg::map_entry_t     rd_data,
	output logic                    busy
);

	pst_pkg::map_entry_t               mem_q [pst_pkg::MAP_DEPTH];
	pst_pkg::map_entry_t               rd_data_q;
	logic [pst_pkg::ID_BITS-1:0]       clr_addr_q;
	logic                              busy_q;
	logic                              wr_en;
	logic [pst_pkg::ID_BITS-1:0]       wr_addr;
	pst_pkg::map_entry_t               wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
		end else if (busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == '1) begin
				busy_q <= 1'b0;
			end
		end
	end

	// The sweep owns the write port until every entry has been invalidated.
	always_comb begin
		wr_en   = busy_q | req.wr_en;
		wr_addr = busy_q ? clr_addr_q : req.wr_addr;
		wr_data = busy_q ? '0 : req.wr_data;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem_q[req.rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = busy_q;

endmodule

`default_nettype wire

/* src/pst_owner_store.sv */
// Slot owner memory: the handle id that lives in each dense slot.
// One write port and one registered read port.
// Depends on pst_pkg.
`default_nettype none

module pst_owner_store (
	input  wire                          clk,
	input  pst_pkg::own_req_t            req,
	output logic [pst_pkg::ID_BITS-1:0]  rd_data
);

	logic [pst_pkg::ID_BITS-1:0] mem_q [pst_pkg::CAPACITY];
	logic [pst_pkg::ID_BITS-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem_q[req.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

/* src/pst_ctrl.sv */
// Sequencer for the packed slot table: issues memory reads, decides the operation,
// writes the memories back and builds the result. Keeps the live count and id counter.
// Depends on pst_pkg.
`default_nettype none

module pst_ctrl (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          req_valid,
	output logic                         req_ready,
	input  pst_pkg::req_t                req,
	input  wire                          out_free,
	output logic                         out_load,
	output pst_pkg::rsp_t                res,
	output pst_pkg::map_req_t            map_req,
	input  pst_pkg::map_entry_t          map_rd,
	input  wire                          map_busy,
	output pst_pkg::own_req_t            own_req,
	input  wire [pst_pkg::ID_BITS-1:0]   own_rd
);

	pst_pkg::fsm_state_t                 state_q, state_d;
	pst_pkg::action_t                    action_q;
	logic [pst_pkg::ID_BITS-1:0]         handle_q;
	logic [pst_pkg::COUNT_BITS-1:0]      count_q, count_n;
	logic [pst_pkg::ID_BITS-1:0]         idctr_q;
	logic                                ctr_inc;
	pst_pkg::rsp_t                       res_q, res_c;

	logic                                accept;
	logic                                live;
	logic                                full;
	logic [pst_pkg::COUNT_BITS-1:0]      last_c;
	logic [pst_pkg::SLOT_BITS-1:0]       last_slot;
	logic                                moving;
	logic                                fix_needed;

	assign accept = req_valid & req_ready;

	// Decode of the memory read data, valid in the execute state.
	always_comb begin
		last_c     = count_q - 1'b1;
		last_slot  = last_c[pst_pkg::SLOT_BITS-1:0];
		full       = (count_q >= pst_pkg::COUNT_BITS'(pst_pkg::CAPACITY));
		live       = map_rd.valid && (pst_pkg::COUNT_BITS'(map_rd.slot) < count_q);
		moving     = (map_rd.slot != last_slot);
		fix_needed = (action_q == pst_pkg::ACT_DESTROY) && live && moving;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pst_pkg::S_IDLE: begin
				if (accept) begin
					state_d = pst_pkg::S_EXEC;
				end
			end
			pst_pkg::S_EXEC: begin
				if (fix_needed) begin
					state_d = pst_pkg::S_FIX;
				end else if (out_free) begin
					state_d = pst_pkg::S_IDLE;
				end else begin
					state_d = pst_pkg::S_DONE;
				end
			end
			pst_pkg::S_FIX, pst_pkg::S_DONE: begin
				state_d = out_free ? pst_pkg::S_IDLE : pst_pkg::S_DONE;
			end
			default: state_d = pst_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		map_req  = '0;
		own_req  = '0;
		res_c    = '0;
		count_n  = count_q;
		ctr_inc  = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			pst_pkg::S_IDLE: begin
				map_req.rd_en   = accept;
				map_req.rd_addr = (req.action == pst_pkg::ACT_CREATE) ?
					idctr_q : req.handle[pst_pkg::ID_BITS-1:0];
				// The owner of the last slot is only needed by a destroy, but reading
				// it for every operation keeps both reads in the same cycle.
				own_req.rd_en   = accept;
				own_req.rd_addr = last_slot;
			end
			pst_pkg::S_EXEC: begin
				case (action_q)
					pst_pkg::ACT_CREATE: begin
						if (full) begin
							res_c.status = pst_pkg::STS_FULL;
						end else if (map_rd.valid) begin
							res_c.status     = pst_pkg::STS_WRAP;
							res_c.new_handle = pst_pkg::HANDLE_W'(idctr_q);
							ctr_inc          = 1'b1;
						end else begin
							map_req.wr_en         = 1'b1;
							map_req.wr_addr       = idctr_q;
							map_req.wr_data.valid = 1'b1;
							map_req.wr_data.slot  = count_q[pst_pkg::SLOT_BITS-1:0];
							own_req.wr_en         = 1'b1;
							own_req.wr_addr       = count_q[pst_pkg::SLOT_BITS-1:0];
							own_req.wr_data       = idctr_q;
							count_n               = count_q + 1'b1;
							ctr_inc               = 1'b1;
							res_c.status          = pst_pkg::STS_OK;
							res_c.new_handle      = pst_pkg::HANDLE_W'(idctr_q);
							res_c.slot            = pst_pkg::SLOT_W'(count_q);
						end
					end
					pst_pkg::ACT_DESTROY: begin
						if (!live) begin
							res_c.status = pst_pkg::STS_DEAD;
						end else begin
							count_n      = last_c;
							res_c.status = pst_pkg::STS_OK;
							res_c.slot   = pst_pkg::SLOT_W'(map_rd.slot);
							map_req.wr_en = 1'b1;
							if (moving) begin
								// Repoint the last slot's owner now; the destroyed
								// handle is invalidated in the next cycle.
								map_req.wr_addr       = own_rd;
								map_req.wr_data.valid = 1'b1;
								map_req.wr_data.slot  = map_rd.slot;
								own_req.wr_en         = 1'b1;
								own_req.wr_addr       = map_rd.slot;
								own_req.wr_data       = own_rd;
								res_c.moved           = 1'b1;
								res_c.moved_from      = pst_pkg::SLOT_W'(last_slot);
							end else begin
								map_req.wr_addr = handle_q;
								map_req.wr_data = '0;
							end
						end
					end
					pst_pkg::ACT_LOOKUP: begin
						if (live) begin
							res_c.status = pst_pkg::STS_OK;
							res_c.slot   = pst_pkg::SLOT_W'(map_rd.slot);
						end else begin
							res_c.status = pst_pkg::STS_DEAD;
						end
					end
					default: res_c.status = pst_pkg::STS_OK;
				endcase
				res_c.live_count = pst_pkg::COUNT_W'(count_n);
				out_load         = out_free && !fix_needed;
			end
			pst_pkg::S_FIX: begin
				map_req.wr_en   = 1'b1;
				map_req.wr_addr = handle_q;
				map_req.wr_data = '0;
				out_load        = out_free;
			end
			pst_pkg::S_DONE: begin
				out_load = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pst_pkg::S_IDLE;
			count_q <= '0;
			idctr_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_n;
			if (ctr_inc) begin
				idctr_q <= idctr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= req.action;
			handle_q <= req.handle[pst_pkg::ID_BITS-1:0];
		end
		if (state_q == pst_pkg::S_EXEC) begin
			res_q <= res_c;
		end
	end

	assign req_ready = (state_q == pst_pkg::S_IDLE) && !map_busy;
	assign res       = (state_q == pst_pkg::S_EXEC) ? res_c : res_q;

endmodule

`default_nettype wire

/* src/packed_slot_table.sv */
// Packed slot table: a dense array of live handles with swap-remove on destroy.
// Request channel (req_valid/req_ready/req) carries an action and a handle id;
// the response channel (rsp_valid/rsp_ready/rsp) returns exactly one result per
// request transfer, in order.
// Create hands out the next id from a wrapping counter at slot live_count if the table
// has room and that id is free; destroy frees a slot and moves the last entry into it;
// lookup returns a live handle's slot. A request reads the handle map and the slot
// owner memory in the idle state and decides and writes back in the execute state; a
// destroy that moves an entry also passes through a fix state, because the handle
// map has a single write port and needs two writes.
// One request is worked on at a time; the next request is taken as soon as the
// previous result sits in the response register.
// Responses are registered. If the receiver stalls, the finished result waits in the
// response register and a second one in the sequencer; after that, req_ready stays
// low until rsp_ready frees the register.
// Reset: the live count and id counter clear at once, then the handle map is
// invalidated by a sweep over all 1024 entries, one entry per cycle, during which
// req_ready is low.
// Depends on pst_pkg, pst_ctrl, pst_map_store and pst_owner_store.
`default_nettype none

module packed_slot_table (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            req_valid,
	output logic           req_ready,
	input  pst_pkg::req_t  req,
	output logic           rsp_valid,
	input  wire            rsp_ready,
	output pst_pkg::rsp_t  rsp
);

	pst_pkg::map_req_t            map_req;
	pst_pkg::map_entry_t          map_rd;
	logic                         map_busy;
	pst_pkg::own_req_t            own_req;
	logic [pst_pkg::ID_BITS-1:0]  own_rd;
	pst_pkg::rsp_t                res;
	logic                         res_load;
	logic                         out_free;
	logic                         rsp_valid_q;
	pst_pkg::rsp_t                rsp_q;

	assign out_free = !rsp_valid_q || rsp_ready;

	pst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.out_free  (out_free),
		.out_load  (res_load),
		.res       (res),
		.map_req   (map_req),
		.map_rd    (map_rd),
		.map_busy  (map_busy),
		.own_req   (own_req),
		.own_rd    (own_rd)
	);

	pst_map_store u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (map_req),
		.rd_data (map_rd),
		.busy    (map_busy)
	);

	pst_owner_store u_owner (
		.clk     (clk),
		.req     (own_req),
		.rd_data (own_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// A result is only loaded when the response register is empty or draining.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (!rsp_valid_q || rsp_ready))
		else $error("result loaded over a pending response");

	// After a move, the freed last slot equals the new live count and lies above the hole.
	a_move_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.moved) |->
			((pst_pkg::COUNT_W'(rsp.moved_from) == rsp.live_count) &&
			 (rsp.slot < rsp.moved_from)))
		else $error("moved entry does not come from the last slot");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.live_count <= pst_pkg::COUNT_W'(pst_pkg::CAPACITY)))
		else $error("live count above capacity");

	// Requests are processed one at a time.
	a_one_open: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("second request taken while one is in progress");

endmodule

`default_nettype wire
